>>> hw/rtl/trapped_water_total_assert.svh
// ----------------------------------------------------------------------------
// Trapped water total assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRAPPED_WATER_TOTAL_ASSERT_SVH
`define TRAPPED_WATER_TOTAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TWT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/twt_pkg.sv
// ----------------------------------------------------------------------------
// Trapped water total package
// Shared state encoding, command and status types and fixed result widths.
// ----------------------------------------------------------------------------
package twt_pkg;

	localparam int WATER_W = 26;
	localparam logic [WATER_W-1:0] TOTAL_MAX = {WATER_W{1'b1}};

	typedef enum logic [1:0] {
		S_LOAD,
		S_WALK,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic arm;
		logic rd;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic rd_last;
		logic out_busy;
	} status_t;

endpackage

>>> hw/rtl/trapped_water_total.sv
// A map loads one bar per cycle while the block is in its load state and in_valid is high.
// After the last bar is accepted the input stalls; the store is read backwards, one read per bar,
// then the sum is finished and the result is published before a new map is taken.
// The walk uses the single read port of the bar store.
// Reset clears all control state; the bar store holds no reset value and is never cleared.
// ----------------------------------------------------------------------------
// Trapped water total
// Loads bar heights, then walks them backwards to sum the trapped water.
// ----------------------------------------------------------------------------
module trapped_water_total import twt_pkg::*; #(
	parameter int MAX_BARS    = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [HEIGHT_BITS-1:0] height,
	input  logic                   last_bar,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [WATER_W-1:0]     water_total,
	output logic                   overflow
);

	cmd_t    cmd;
	status_t status;

	twt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last_bar (last_bar),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status)
	);

	twt_dp #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.height      (height),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.water_total (water_total),
		.overflow    (overflow)
	);

endmodule

>>> hw/rtl/twt_ctrl.sv
// ----------------------------------------------------------------------------
// Trapped water total controller
// Sequences loading, the backward walk over the store and result hand-off.
// ----------------------------------------------------------------------------
module twt_ctrl import twt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    last_bar,
	output logic    in_stall,
	output cmd_t    cmd,
	input  status_t status
);

	state_t state_q;
	state_t state_n;
	logic   accept;

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_LOAD: begin
				if (accept && last_bar) begin
					state_n = S_WALK;
				end
			end
			S_WALK: begin
				if (status.rd_last) begin
					state_n = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_n = S_DONE;
			end
			S_DONE: begin
				if (!status.out_busy) begin
					state_n = S_LOAD;
				end
			end
			default: begin
				state_n = S_LOAD;
			end
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd         = '0;
		case (state_q)
			S_LOAD: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
				cmd.arm  = in_valid && last_bar;
			end
			S_WALK: begin
				cmd.rd = 1'b1;
			end
			S_DRAIN: begin
				cmd = '0;
			end
			S_DONE: begin
				cmd.publish = !status.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/twt_dp.sv
// ----------------------------------------------------------------------------
// Trapped water total datapath
// Bar store with prefix maxima, suffix maximum walk, saturating total.
// ----------------------------------------------------------------------------
`include "trapped_water_total_assert.svh"

module twt_dp import twt_pkg::*; #(
	parameter int MAX_BARS    = 1024,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic [HEIGHT_BITS-1:0] height,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [WATER_W-1:0]     water_total,
	output logic                   overflow
);

	localparam int CNT_W = $clog2(MAX_BARS + 1);
	localparam int IDX_W = $clog2(MAX_BARS);
	localparam int ACC_W = ((HEIGHT_BITS > WATER_W) ? HEIGHT_BITS : WATER_W) + 1;

	logic [2*HEIGHT_BITS-1:0] mem [MAX_BARS];

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_n;
	logic                     room;
	logic [HEIGHT_BITS-1:0]   pmax_q;
	logic [HEIGHT_BITS-1:0]   pmax_n;
	logic                     ovf_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic                     valid_s1;
	logic [2*HEIGHT_BITS-1:0] rd_data_s1;
	logic [HEIGHT_BITS-1:0]   rd_b;
	logic [HEIGHT_BITS-1:0]   rd_p;
	logic [HEIGHT_BITS-1:0]   suffix_q;
	logic [HEIGHT_BITS-1:0]   suffix_n;
	logic [HEIGHT_BITS-1:0]   lim;
	logic [ACC_W-1:0]         sum;
	logic [WATER_W-1:0]       acc_q;
	logic [WATER_W-1:0]       acc_n;
	logic                     out_valid_q;
	logic [WATER_W-1:0]       water_q;
	logic                     ovf_out_q;

	assign room    = count_q < CNT_W'(MAX_BARS);
	assign count_n = count_q + CNT_W'(room);
	assign pmax_n  = (height > pmax_q) ? height : pmax_q;

	assign rd_b     = rd_data_s1[2*HEIGHT_BITS-1:HEIGHT_BITS];
	assign rd_p     = rd_data_s1[HEIGHT_BITS-1:0];
	assign suffix_n = (rd_b > suffix_q) ? rd_b : suffix_q;
	assign lim      = (rd_p < suffix_n) ? rd_p : suffix_n;
	assign sum      = ACC_W'(acc_q) + ACC_W'(lim - rd_b);
	assign acc_n    = (sum > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[WATER_W-1:0];

	assign status.rd_last  = (rd_idx_q == '0);
	assign status.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			mem[count_q[IDX_W-1:0]] <= {height, pmax_n};
		end
		if (cmd.rd) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pmax_q      <= '0;
			ovf_q       <= 1'b0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			suffix_q    <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd;
			if (cmd.load) begin
				if (room) begin
					count_q <= count_n;
					pmax_q  <= pmax_n;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.arm) begin
				rd_idx_q <= IDX_W'(count_n - CNT_W'(1));
			end else if (cmd.rd) begin
				rd_idx_q <= rd_idx_q - IDX_W'(1);
			end
			if (valid_s1) begin
				suffix_q <= suffix_n;
				acc_q    <= acc_n;
			end
			if (cmd.publish) begin
				count_q     <= '0;
				pmax_q      <= '0;
				ovf_q       <= 1'b0;
				suffix_q    <= '0;
				acc_q       <= '0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			water_q   <= acc_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign water_total = water_q;
	assign overflow    = ovf_out_q;

	`TWT_ASSERT_SAME(a_rd_in_range, cmd.rd, CNT_W'(rd_idx_q) < count_q, "walk read beyond stored bars")
	`TWT_ASSERT_SAME(a_bar_below_prefix, valid_s1, rd_b <= rd_p, "stored bar above its prefix maximum")
	`TWT_ASSERT_SAME(a_publish_drained, cmd.publish, !valid_s1, "result published with a read pending")
	`TWT_ASSERT_NEXT(a_publish_clears, cmd.publish, out_valid_q && count_q == '0, "map not cleared after result")

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Trapped water total testbench
// Streams elevation maps into the block and predicts the trapped water total
// and overflow flag of each map, including the short map, the full store,
// the overflowing store and the largest possible total. Both channels idle
// and stall at random in two of three patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
	import twt_pkg::*;

	localparam int MAX_BARS       = 1024;
	localparam int HEIGHT_BITS    = 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD      = 400;
	localparam int HOLD_AT_RESULT = 5;
	localparam int SETTLE_CYCLES  = 16;

	typedef struct {
		logic [HEIGHT_BITS-1:0] h;
		logic                   last;
	} bar_req_t;

	typedef struct {
		logic [WATER_W-1:0] water;
		logic               ovf;
	} water_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [HEIGHT_BITS-1:0] height = '0;
	logic                   last_bar = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [WATER_W-1:0]     water_total;
	logic                   overflow;

	bar_req_t      bar_req_q[$];
	water_result_t water_expect_q[$];

	logic [HEIGHT_BITS-1:0] stored_h[MAX_BARS];
	logic [HEIGHT_BITS-1:0] stored_pmax[MAX_BARS];
	int                     stored_cnt = 0;
	logic [HEIGHT_BITS-1:0] prefix_top = '0;
	logic                   store_overflowed = 1'b0;

	int send_idle_pct = 11;
	int stall_pct = 84;
	int hold_cnt = 0;
	bit hold_done = 1'b0;
	int idle_cycles = 0;
	int error_cnt = 0;
	int bars_queued = 0;
	int maps_queued = 0;
	int results_got = 0;
	int overflow_results = 0;

	trapped_water_total #(
		.MAX_BARS(MAX_BARS),
		.HEIGHT_BITS(HEIGHT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.height(height),
		.last_bar(last_bar),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.water_total(water_total),
		.overflow(overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_cnt++;
	endtask

	// Stores the bar and, on the final bar, sums the water of the map.
	task automatic absorb_bar(input logic [HEIGHT_BITS-1:0] h, input logic last);
		logic [HEIGHT_BITS-1:0] suffix_top;
		logic [HEIGHT_BITS-1:0] lim;
		longint                 sum;
		water_result_t          res;
		if (stored_cnt < MAX_BARS) begin
			if (h > prefix_top)
				prefix_top = h;
			stored_h[stored_cnt] = h;
			stored_pmax[stored_cnt] = prefix_top;
			stored_cnt++;
		end else begin
			store_overflowed = 1'b1;
		end
		if (last) begin
			suffix_top = '0;
			sum = 0;
			for (int i = stored_cnt - 1; i >= 0; i--) begin
				if (stored_h[i] > suffix_top)
					suffix_top = stored_h[i];
				lim = (stored_pmax[i] < suffix_top) ? stored_pmax[i] : suffix_top;
				sum += longint'(lim - stored_h[i]);
				if (sum > longint'(TOTAL_MAX))
					sum = longint'(TOTAL_MAX);
			end
			res.water = sum[WATER_W-1:0];
			res.ovf = store_overflowed;
			water_expect_q.push_back(res);
			stored_cnt = 0;
			prefix_top = '0;
			store_overflowed = 1'b0;
		end
	endtask

	task automatic push_bar(input int h, input bit last);
		bar_req_t r;
		r.h = h[HEIGHT_BITS-1:0];
		r.last = last;
		bar_req_q.push_back(r);
		bars_queued++;
		if (last)
			maps_queued++;
	endtask

	task automatic add_random_map();
		int len;
		int kind;
		int h;
		kind = $urandom_range(0, 9);
		if (kind <= 5)
			len = $urandom_range(3, 10);
		else if (kind <= 8)
			len = $urandom_range(11, 40);
		else
			len = $urandom_range(1, 2);
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(0, 3))
				0: h = $urandom_range(0, 65535);
				1: h = $urandom_range(0, 15);
				2: h = $urandom_range(0, 1) ? 65535 : 0;
				default: h = $urandom_range(65520, 65535);
			endcase
			push_bar(h, k == len - 1);
		end
	endtask

	task automatic fill_random(input int n_bars);
		int start;
		start = bars_queued;
		while (bars_queued - start < n_bars)
			add_random_map();
	endtask

	task automatic drain_all();
		while (bar_req_q.size() != 0 || in_valid || water_expect_q.size() != 0)
			@(negedge clk);
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		bar_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			height <= '0;
			last_bar <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				absorb_bar(height, last_bar);
			if (bar_req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				r = bar_req_q.pop_front();
				in_valid <= 1'b1;
				height <= r.h;
				last_bar <= r.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result monitor and output stall.
	always @(posedge clk or negedge arst_n) begin
		water_result_t exp_res;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_got++;
				if (overflow)
					overflow_results++;
				if (water_expect_q.size() == 0) begin
					flag_error($sformatf("unexpected result water=%0d overflow=%0b",
						water_total, overflow));
				end else begin
					exp_res = water_expect_q.pop_front();
					if (water_total !== exp_res.water)
						flag_error($sformatf("water_total got %0d expected %0d",
							water_total, exp_res.water));
					if (overflow !== exp_res.ovf)
						flag_error($sformatf("overflow got %0b expected %0b",
							overflow, exp_res.ovf));
				end
				if (results_got == HOLD_AT_RESULT && !hold_done) begin
					hold_cnt = LONG_HOLD;
					hold_done = 1'b1;
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Short maps, extreme heights, flat and valley shapes.
		push_bar(65535, 1);
		push_bar(0, 0); push_bar(65535, 1);
		push_bar(7, 0); push_bar(0, 0); push_bar(7, 1);
		push_bar(65535, 0); push_bar(0, 0); push_bar(65535, 1);
		push_bar(0, 0); push_bar(65535, 0); push_bar(0, 1);
		push_bar(3, 0); push_bar(1, 0); push_bar(2, 0); push_bar(1, 0); push_bar(4, 1);
		push_bar(0, 0); push_bar(0, 0); push_bar(0, 1);
		push_bar(5, 0); push_bar(4, 0); push_bar(3, 0); push_bar(4, 0); push_bar(5, 1);
		fill_random(100);
		drain_all();

		send_idle_pct = 84;
		stall_pct = 11;
		fill_random(80);
		drain_all();

		send_idle_pct = 0;
		stall_pct = 0;
		fill_random(20);
		// A full store holding the largest possible total, followed by bars
		// past the store capacity that are dropped, the final one included.
		push_bar(65535, 0);
		for (int k = 0; k < MAX_BARS - 2; k++)
			push_bar(0, 0);
		push_bar(65535, 0);
		for (int k = 0; k < 6; k++)
			push_bar($urandom_range(0, 65535), k == 5);
		drain_all();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d maps with %0d bars under three idle patterns, incl. full store.",
			maps_queued, bars_queued);
		$display("Checked %0d results (%0d with overflow), %0d errors.",
			results_got, overflow_results, error_cnt);
		if (error_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/twt_pkg.sv
hw/rtl/twt_ctrl.sv
hw/rtl/twt_dp.sv
hw/rtl/trapped_water_total.sv
dv/tb.sv
